@@ hw/rtl/rls_pkg.sv @@
package rls_pkg;

   localparam int RAM_BYTES = 16;

   localparam int OP_WIDTH = 2;
   localparam int STATUS_WIDTH = 2;
   localparam int ADDRESS_WIDTH = 4;
   localparam int LOAD_ADDRESS_WIDTH = 5;
   localparam int BYTE_WIDTH = 8;
   localparam int STEP_WIDTH = 6;
   localparam int WAIT_WIDTH = 16;
   localparam int DELAY_WIDTH = 8;
   localparam int PROGRAM_WIDTH = 64;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 24;

   localparam logic [OP_WIDTH-1:0] OP_TICK = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_START = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_ABORT = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_CLOCK_NOT_MANUAL = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_RAM_NOT_RUN = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROGRAM_LOW = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROGRAM_HIGH = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_DELAY = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_DELAY = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESET_DELAY = 3'd4;

   localparam logic [WAIT_WIDTH-1:0] START_DELAY_RESET = 16'd250;
   localparam logic [DELAY_WIDTH-1:0] STEP_DELAY_RESET = 8'd10;
   localparam logic [DELAY_WIDTH-1:0] RESET_DELAY_RESET = 8'd5;

   localparam logic [STEP_WIDTH-1:0] STEP_CONTROL_ON = 6'd0;
   localparam logic [STEP_WIDTH-1:0] STEP_DATA_ON = 6'd1;
   localparam logic [STEP_WIDTH-1:0] STEP_RESET_PRESS = STEP_WIDTH'(2 + 3 * RAM_BYTES);
   localparam logic [STEP_WIDTH-1:0] STEP_RESET_RELEASE = STEP_WIDTH'(3 + 3 * RAM_BYTES);
   localparam logic [STEP_WIDTH-1:0] STEP_DATA_OFF = STEP_WIDTH'(4 + 3 * RAM_BYTES);

   typedef enum logic [1:0] {
      PHASE_PRESENT,
      PHASE_WRITE_HIGH,
      PHASE_WRITE_LOW
   } rls_phase_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0] operation;
      logic                clock_manual;
      logic                ram_run;
   } rls_item_type;

   typedef struct packed {
      logic                     control_enable;
      logic                     data_enable;
      logic [ADDRESS_WIDTH-1:0] ram_address;
      logic [BYTE_WIDTH-1:0]    ram_value;
      logic                     ram_write;
      logic                     reset_press;
   } rls_drive_type;

   typedef struct packed {
      rls_drive_type             drive;
      logic                      busy_res;
      logic [STATUS_WIDTH-1:0]   status;
      logic                      finished;
   } rls_result_type;

   typedef struct packed {
      logic [PROGRAM_WIDTH-1:0] program_bytes_low;
      logic [PROGRAM_WIDTH-1:0] program_bytes_high;
      logic [WAIT_WIDTH-1:0]    start_delay;
      logic [DELAY_WIDTH-1:0]   step_delay;
      logic [DELAY_WIDTH-1:0]   reset_delay;
   } rls_cfg_type;

endpackage

@@ hw/rtl/rls_csr.sv @@
module rls_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [rls_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [rls_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output rls_pkg::rls_cfg_type                 cfg
);
   import rls_pkg::*;

   rls_cfg_type cfg_ff;
   rls_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PROGRAM_LOW:  cfg_in.program_bytes_low = csr_wdata;
            CSR_PROGRAM_HIGH: cfg_in.program_bytes_high = csr_wdata;
            CSR_START_DELAY:  cfg_in.start_delay = csr_wdata[WAIT_WIDTH-1:0];
            CSR_STEP_DELAY:   cfg_in.step_delay = csr_wdata[DELAY_WIDTH-1:0];
            CSR_RESET_DELAY:  cfg_in.reset_delay = csr_wdata[DELAY_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.program_bytes_low <= '0;
         cfg_ff.program_bytes_high <= '0;
         cfg_ff.start_delay <= START_DELAY_RESET;
         cfg_ff.step_delay <= STEP_DELAY_RESET;
         cfg_ff.reset_delay <= RESET_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/rls_input_stage.sv @@
module rls_input_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  take,
   input  rls_pkg::rls_item_type req_item,
   output logic                  item_valid,
   output rls_pkg::rls_item_type item
);
   import rls_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rls_item_type item_ff;

   assign valid_in = accept | (valid_ff & ~take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

@@ hw/rtl/rls_core.sv @@
module rls_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  rls_pkg::rls_item_type   item,
   input  rls_pkg::rls_cfg_type    cfg,
   output rls_pkg::rls_result_type result
);
   import rls_pkg::*;

   logic                          active_ff, active_in;
   logic [STEP_WIDTH-1:0]         step_ff, step_in;
   rls_phase_type                 phase_ff, phase_in;
   logic [LOAD_ADDRESS_WIDTH-1:0] load_address_ff, load_address_in;
   logic [WAIT_WIDTH-1:0]         wait_ff, wait_in;
   rls_drive_type                 drive_ff, drive_in;
   logic [WAIT_WIDTH-1:0]         wait_dec;
   logic [WAIT_WIDTH-1:0]         step_wait;
   logic [WAIT_WIDTH-1:0]         reset_wait;
   logic [2*PROGRAM_WIDTH-1:0]    program_bytes;
   logic [BYTE_WIDTH-1:0]         program_byte;
   logic [STATUS_WIDTH-1:0]       status;
   logic                          finished;

   assign program_bytes = {cfg.program_bytes_high, cfg.program_bytes_low};
   assign program_byte = program_bytes[load_address_ff[ADDRESS_WIDTH-1:0] * BYTE_WIDTH +: BYTE_WIDTH];
   assign step_wait = WAIT_WIDTH'(cfg.step_delay);
   assign reset_wait = WAIT_WIDTH'(cfg.reset_delay);
   assign wait_dec = (wait_ff != '0) ? wait_ff - WAIT_WIDTH'(1) : wait_ff;

   always_comb begin
      active_in = active_ff;
      step_in = step_ff;
      phase_in = phase_ff;
      load_address_in = load_address_ff;
      wait_in = wait_ff;
      drive_in = drive_ff;
      status = STATUS_OK;
      finished = 1'b0;
      unique case (item.operation)
         OP_TICK: begin
            if (active_ff) begin
               wait_in = wait_dec;
               if (wait_dec == '0) begin
                  step_in = step_ff + STEP_WIDTH'(1);
                  wait_in = step_wait;
                  if (step_ff == STEP_CONTROL_ON) begin
                     drive_in.control_enable = 1'b1;
                  end else if (step_ff == STEP_DATA_ON) begin
                     drive_in.data_enable = 1'b1;
                  end else if (step_ff < STEP_RESET_PRESS) begin
                     case (phase_ff)
                        PHASE_PRESENT: begin
                           drive_in.ram_address = load_address_ff[ADDRESS_WIDTH-1:0];
                           drive_in.ram_value = program_byte;
                           phase_in = PHASE_WRITE_HIGH;
                        end
                        PHASE_WRITE_HIGH: begin
                           drive_in.ram_write = 1'b1;
                           phase_in = PHASE_WRITE_LOW;
                        end
                        default: begin
                           drive_in.ram_write = 1'b0;
                           load_address_in = load_address_ff + LOAD_ADDRESS_WIDTH'(1);
                           phase_in = PHASE_PRESENT;
                        end
                     endcase
                  end else if (step_ff == STEP_RESET_PRESS) begin
                     drive_in.reset_press = 1'b1;
                     wait_in = reset_wait;
                  end else if (step_ff == STEP_RESET_RELEASE) begin
                     drive_in.reset_press = 1'b0;
                     wait_in = reset_wait;
                  end else if (step_ff == STEP_DATA_OFF) begin
                     drive_in.data_enable = 1'b0;
                  end else begin
                     drive_in.control_enable = 1'b0;
                     active_in = 1'b0;
                     step_in = '0;
                     wait_in = wait_dec;
                     finished = 1'b1;
                  end
               end
            end
         end
         OP_START: begin
            if (!active_ff) begin
               if (!item.clock_manual) begin
                  status = STATUS_CLOCK_NOT_MANUAL;
               end else if (!item.ram_run) begin
                  status = STATUS_RAM_NOT_RUN;
               end else begin
                  step_in = '0;
                  phase_in = PHASE_PRESENT;
                  load_address_in = '0;
                  drive_in.ram_write = 1'b0;
                  drive_in.reset_press = 1'b0;
                  drive_in.ram_address = '0;
                  drive_in.ram_value = '0;
                  wait_in = cfg.start_delay;
                  active_in = 1'b1;
               end
            end
         end
         OP_ABORT: begin
            if (active_ff) begin
               drive_in.control_enable = 1'b0;
               drive_in.data_enable = 1'b0;
               active_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff <= '0;
         phase_ff <= PHASE_PRESENT;
         load_address_ff <= '0;
         wait_ff <= '0;
         drive_ff <= '0;
      end else if (fire) begin
         active_ff <= active_in;
         step_ff <= step_in;
         phase_ff <= phase_in;
         load_address_ff <= load_address_in;
         wait_ff <= wait_in;
         drive_ff <= drive_in;
      end
   end

   assign result.drive = drive_in;
   assign result.busy_res = active_in;
   assign result.status = status;
   assign result.finished = finished;

endmodule

@@ hw/rtl/rls_output_stage.sv @@
module rls_output_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic                    rsp_tready,
   input  rls_pkg::rls_result_type result,
   output logic                    result_valid,
   output rls_pkg::rls_result_type result_held
);
   import rls_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   rls_result_type result_ff;

   assign valid_in = fire | (valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result;
      end
   end

   assign result_valid = valid_ff;
   assign result_held = result_ff;

endmodule

@@ hw/rtl/ram_loader_sequencer.sv @@
// Loads a 16-byte program into a target RAM by a timed sequence of drive levels. Each input
// item is a one-millisecond tick, a start request or an abort, and each gives exactly one
// result item with the drive levels after it, the busy flag, a start status and the finished
// flag (carried on rsp_tlast). Items are taken one per clock cycle while the result side
// keeps up: an input register feeds the step logic, whose result lands in an output register.
// The block does not hold back configuration writes, so write the registers only while no
// item is in flight.
module ram_loader_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: clock_manual, ram_run, zero fill.
   input  logic [rls_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // Fields from bit 0: operation.
   input  logic [rls_pkg::OP_WIDTH-1:0]         req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0: control_enable, data_enable, ram_address, ram_value, ram_write,
   // reset_press, busy_res, status, zero fill.
   output logic [rls_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [rls_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [rls_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import rls_pkg::*;

   rls_cfg_type    cfg;
   rls_item_type   req_item;
   rls_item_type   item;
   rls_result_type result;
   rls_result_type result_held;
   logic           item_valid;
   logic           accept;
   logic           fire;

   assign req_item.operation = req_tuser;
   assign req_item.clock_manual = req_tdata[0];
   assign req_item.ram_run = req_tdata[1];

   assign fire = item_valid & (~rsp_tvalid | rsp_tready);
   assign req_tready = ~item_valid | fire;
   assign accept = req_tvalid & req_tready;

   rls_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rls_input_stage u_input_stage (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .take       (fire),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item)
   );

   rls_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .cfg    (cfg),
      .result (result)
   );

   rls_output_stage u_output_stage (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .rsp_tready   (rsp_tready),
      .result       (result),
      .result_valid (rsp_tvalid),
      .result_held  (result_held)
   );

   assign rsp_tdata = {5'd0,
                       result_held.status,
                       result_held.busy_res,
                       result_held.drive.reset_press,
                       result_held.drive.ram_write,
                       result_held.drive.ram_value,
                       result_held.drive.ram_address,
                       result_held.drive.data_enable,
                       result_held.drive.control_enable};
   assign rsp_tlast = result_held.finished;

   a_finished_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result_held.finished |->
         !result_held.busy_res && !result_held.drive.control_enable)
      else $error("finished result still shows a busy sequence");

   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !result_held.busy_res |->
         !result_held.drive.control_enable && !result_held.drive.data_enable)
      else $error("drive enabled while no sequence is running");

   a_refused_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result_held.status != STATUS_OK |->
         !result_held.busy_res && !result_held.finished)
      else $error("refused start reported with a running sequence");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !fire)
      else $error("result register loaded while a result is still waiting");

endmodule
